[rtl/core/shs_pkg.sv]
// shared types, constants and round functions for the sha-256 stream hasher
package shs_pkg;

    typedef logic [31:0] word_t;

    // control from the sequencer to the compression core
    typedef struct packed {
        logic start;  // load working vars from chain and run one block
        logic init;   // put chain back to the initial hash values
    } core_ctl_t;

    // status from the compression core
    typedef struct packed {
        logic busy;      // block in flight
        logic rounding;  // a round consumes the schedule word this cycle
    } core_sts_t;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned BLOCK_WORDS = BLOCK_BYTES / 4;
    localparam int unsigned LEN_OFFSET  = 56;
    localparam logic [7:0]  PAD_BYTE    = 8'h80;

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t big_sig0(input word_t x);
        big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sig1(input word_t x);
        big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sig0(input word_t x);
        small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sig1(input word_t x);
        small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t choose(input word_t e, input word_t f, input word_t g);
        choose = (e & f) ^ (~e & g);
    endfunction

    function automatic word_t majority(input word_t a, input word_t b, input word_t c);
        majority = (a & b) ^ (a & c) ^ (b & c);
    endfunction

    function automatic word_t chain_iv(input logic [2:0] idx);
        unique case (idx)
            3'd0: chain_iv = 32'h6a09e667;
            3'd1: chain_iv = 32'hbb67ae85;
            3'd2: chain_iv = 32'h3c6ef372;
            3'd3: chain_iv = 32'ha54ff53a;
            3'd4: chain_iv = 32'h510e527f;
            3'd5: chain_iv = 32'h9b05688c;
            3'd6: chain_iv = 32'h1f83d9ab;
            3'd7: chain_iv = 32'h5be0cd19;
            default: chain_iv = 32'h0;
        endcase
    endfunction

    function automatic word_t round_k(input logic [5:0] t);
        unique case (t)
            6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
            default: round_k = 32'h0;
        endcase
    endfunction

endpackage

[rtl/core/shs_core.sv]
// sha-256 compression core: chain words, working vars and one round per cycle
module shs_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  shs_pkg::core_ctl_t  ctl,
    input  shs_pkg::word_t      sched_word,
    input  logic [2:0]          rd_idx,
    output shs_pkg::core_sts_t  sts,
    output shs_pkg::word_t      rd_word
);

    localparam logic [1:0] C_IDLE  = 2'd0;
    localparam logic [1:0] C_ROUND = 2'd1;
    localparam logic [1:0] C_ADD   = 2'd2;

    logic [1:0]     state_reg, state_next;
    logic [5:0]     round_reg, round_next;
    shs_pkg::word_t chain_reg [8];
    shs_pkg::word_t chain_next [8];
    shs_pkg::word_t var_reg [8];
    shs_pkg::word_t var_next [8];
    shs_pkg::word_t tmp1;
    shs_pkg::word_t tmp2;

    // one round of the shared datapath
    always_comb
    begin
        tmp1 = var_reg[7] + shs_pkg::big_sig1(var_reg[4])
             + shs_pkg::choose(var_reg[4], var_reg[5], var_reg[6])
             + shs_pkg::round_k(round_reg) + sched_word;
        tmp2 = shs_pkg::big_sig0(var_reg[0])
             + shs_pkg::majority(var_reg[0], var_reg[1], var_reg[2]);
    end

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        chain_next = chain_reg;
        var_next   = var_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (ctl.start)
                begin
                    var_next   = chain_reg;
                    round_next = '0;
                    state_next = C_ROUND;
                end
            end
            C_ROUND:
            begin
                var_next[7] = var_reg[6];
                var_next[6] = var_reg[5];
                var_next[5] = var_reg[4];
                var_next[4] = var_reg[3] + tmp1;
                var_next[3] = var_reg[2];
                var_next[2] = var_reg[1];
                var_next[1] = var_reg[0];
                var_next[0] = tmp1 + tmp2;
                round_next  = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = C_ADD;
                end
            end
            C_ADD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + var_reg[i];
                end
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
        if (ctl.init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_next[i] = shs_pkg::chain_iv(3'(i));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            round_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= shs_pkg::chain_iv(3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        var_reg <= var_next;
    end

    assign sts.busy     = (state_reg != C_IDLE);
    assign sts.rounding = (state_reg == C_ROUND);
    assign rd_word      = chain_reg[rd_idx];

endmodule

[rtl/core/sha256_stream_hasher_unit.sv]
// sha-256 stream hasher top level: byte buffer, message schedule, padding and digest output
//
//  channel | signals                                  | dir | item
//  --------+------------------------------------------+-----+------------------------------
//  in      | in_valid, in_stall, command, message_byte | in  | one byte to absorb, or finish
//  out     | out_valid, out_stall, digest_word,        | out | one big-endian digest word
//          | word_index, last_word                     |     |
//
// an absorb item is taken while idle; the byte that completes a 64-byte block
// holds the input off through a compression (start, 64 rounds, chain add, handoff)
// a finish item pads as it is taken and runs one or two such compressions, then
// emits eight words, one per cycle when out_stall is low; input stays stalled
// until the eighth word is taken
// the compression core does one round per cycle and sets the block timing
// rst_n clears the sequencer and counters and sets the chain words to the initial
// hash values; out_stall only holds the current word in place
module sha256_stream_hasher_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [7:0]  message_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FULL  = 3'd1;  // compressing a block filled by absorbs
    localparam logic [2:0] S_PAD1  = 3'd2;  // compressing first of two padding blocks
    localparam logic [2:0] S_PAD2  = 3'd3;  // compressing the block with the length
    localparam logic [2:0] S_OUT   = 3'd4;  // emitting digest words

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic        start_reg, start_next;
    logic        init_reg, init_next;
    logic [2:0]  idx_reg, idx_next;
    logic        ovalid_reg, ovalid_next;

    // block buffer doubles as the 16-word schedule window
    shs_pkg::word_t win_reg [shs_pkg::BLOCK_WORDS];
    shs_pkg::word_t win_next [shs_pkg::BLOCK_WORDS];
    shs_pkg::word_t sched_new;

    shs_pkg::core_ctl_t ctl;
    shs_pkg::core_sts_t sts;
    shs_pkg::word_t     rd_word;

    logic in_acc;
    logic out_acc;
    logic core_done;

    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = ovalid_reg && !out_stall;
    assign core_done = !start_reg && !sts.busy;

    // next schedule word from the window taps
    assign sched_new = win_reg[0] + shs_pkg::small_sig0(win_reg[1]) + win_reg[9]
                     + shs_pkg::small_sig1(win_reg[14]);

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        bits_next   = bits_reg;
        start_next  = 1'b0;
        init_next   = 1'b0;
        idx_next    = idx_reg;
        ovalid_next = ovalid_reg;
        win_next    = win_reg;

        // rounds eat the window from the front
        if (sts.rounding)
        begin
            for (int i = 0; i < shs_pkg::BLOCK_WORDS - 1; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[shs_pkg::BLOCK_WORDS - 1] = sched_new;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && command == CMD_ABSORB)
                begin
                    win_next[fill_reg[5:2]][8 * (3 - fill_reg[1:0]) +: 8] = message_byte;
                    bits_next = bits_reg + 64'd8;
                    fill_next = fill_reg + 6'd1;
                    if (fill_reg == 6'(shs_pkg::BLOCK_BYTES - 1))
                    begin
                        start_next = 1'b1;
                        state_next = S_FULL;
                    end
                end
                else if (in_acc && command == CMD_FINISH)
                begin
                    // pad byte, zeros above it, length if it still fits
                    for (int p = 0; p < shs_pkg::BLOCK_BYTES; p++)
                    begin
                        if (6'(p) == fill_reg)
                        begin
                            win_next[p / 4][8 * (3 - p % 4) +: 8] = shs_pkg::PAD_BYTE;
                        end
                        else if (6'(p) > fill_reg)
                        begin
                            if (p >= shs_pkg::LEN_OFFSET
                                && fill_reg < 6'(shs_pkg::LEN_OFFSET))
                            begin
                                win_next[p / 4][8 * (3 - p % 4) +: 8] =
                                    bits_reg[8 * ((shs_pkg::BLOCK_BYTES - 1 - p) & 7) +: 8];
                            end
                            else
                            begin
                                win_next[p / 4][8 * (3 - p % 4) +: 8] = 8'h00;
                            end
                        end
                    end
                    start_next = 1'b1;
                    state_next = (fill_reg >= 6'(shs_pkg::LEN_OFFSET)) ? S_PAD1 : S_PAD2;
                end
            end
            S_FULL:
            begin
                if (core_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_PAD1:
            begin
                if (core_done)
                begin
                    // second block: zeros then the length
                    for (int i = 0; i < shs_pkg::BLOCK_WORDS - 2; i++)
                    begin
                        win_next[i] = '0;
                    end
                    win_next[shs_pkg::BLOCK_WORDS - 2] = bits_reg[63:32];
                    win_next[shs_pkg::BLOCK_WORDS - 1] = bits_reg[31:0];
                    start_next = 1'b1;
                    state_next = S_PAD2;
                end
            end
            S_PAD2:
            begin
                if (core_done)
                begin
                    idx_next    = '0;
                    ovalid_next = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_acc)
                begin
                    if (idx_reg == 3'd7)
                    begin
                        ovalid_next = 1'b0;
                        init_next   = 1'b1;
                        fill_next   = '0;
                        bits_next   = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            bits_reg   <= '0;
            start_reg  <= 1'b0;
            init_reg   <= 1'b0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            bits_reg   <= bits_next;
            start_reg  <= start_next;
            init_reg   <= init_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    assign ctl.start = start_reg;
    assign ctl.init  = init_reg;

    shs_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sched_word (win_reg[0]),
        .rd_idx     (idx_reg),
        .sts        (sts),
        .rd_word    (rd_word)
    );

    // init pulse lands with the return to idle, so the chain is fresh for the next item
    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = ovalid_reg;
    assign digest_word = rd_word;
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 3'd7);

endmodule

[rtl/core/shs_checker.sv]
// port-level checker for the sha-256 stream hasher, bound to the top level
module shs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        command,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last_word
);

    // stalled digest word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(digest_word) && $stable(word_index))
        else $error("digest item changed while stalled");

    // words go out in order with no gap in the index
    a_out_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_word
            |=> out_valid && word_index == $past(word_index) + 3'd1)
        else $error("digest words out of order");

    // last mark only on the eighth word
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd7)))
        else $error("last_word mismatch");

    // no input is taken while the digest is being emitted
    a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted during digest output");

    // a finish always holds off the next item
    a_finish_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && command |=> in_stall)
        else $error("finish did not stall input");

endmodule

bind sha256_stream_hasher_unit shs_checker u_shs_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last_word    (last_word)
);

[tb/shs_tb_pkg.sv]
// command codes and expected digest word layout shared by the sha-256 hasher testbench
`timescale 1ns / 100ps

package shs_tb_pkg;

    typedef enum logic {
        CMD_ABSORB = 1'b0,
        CMD_FINISH = 1'b1
    } hash_cmd_e;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  word_pos;
        logic        last_mark;
    } digest_word_t;

endpackage

[tb/sha256_digest_checker.sv]
// digest predictor and scoreboard that watches both channels of the sha-256 stream hasher
`timescale 1ns / 100ps

module sha256_digest_checker
    import shs_pkg::*;
    import shs_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        command,
    input  logic [7:0]  message_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] digest_word,
    input  logic [2:0]  word_index,
    input  logic        last_word,
    output int          mismatch_count,
    output int          words_pending,
    output int          words_checked
);

    localparam int PRINT_LIMIT = 40;

    localparam logic [0:63][31:0] ROUND_CONST = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [0:7][31:0] CHAIN_START = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    word_t        chain_h [8];
    logic [7:0]   blk [64];
    logic [5:0]   fill;
    logic [63:0]  bit_len;
    digest_word_t expected_words [$];

    function automatic word_t ror32(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic restart_digest();
        for (int i = 0; i < 8; i++)
            chain_h[i] = CHAIN_START[i];
        fill    = '0;
        bit_len = '0;
    endtask

    // one 64-round compression of blk into the chaining words
    task automatic fold_block();
        word_t w [64];
        word_t a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
        e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
               + ROUND_CONST[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
        chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
    endtask

    task automatic absorb_byte(input logic [7:0] value);
        blk[fill] = value;
        bit_len   = bit_len + 64'd8;
        fill      = fill + 6'd1;
        if (fill == 6'd0)
            fold_block();
    endtask

    // pad, append the bit length, and queue the eight digest words
    task automatic close_message();
        int           pos;
        digest_word_t dw;
        pos      = fill;
        blk[pos] = PAD_BYTE;
        pos      = pos + 1;
        // no room left for the length: pad out and spill into a second block
        if (pos > LEN_OFFSET)
        begin
            for (int i = pos; i < BLOCK_BYTES; i++)
                blk[i] = 8'h00;
            fold_block();
            pos = 0;
        end
        for (int i = pos; i < LEN_OFFSET; i++)
            blk[i] = 8'h00;
        for (int i = 0; i < 8; i++)
            blk[LEN_OFFSET + i] = bit_len[63 - 8*i -: 8];
        fold_block();
        for (int i = 0; i < 8; i++)
        begin
            dw.word      = chain_h[i];
            dw.word_pos  = 3'(i);
            dw.last_mark = (i == 7);
            expected_words.push_back(dw);
        end
        restart_digest();
    endtask

    task automatic check_word();
        digest_word_t want;
        if (expected_words.size() == 0)
        begin
            report_mismatch("digest word with none pending", digest_word, 32'h0);
            return;
        end
        want = expected_words.pop_front();
        if (digest_word !== want.word)
            report_mismatch("digest_word", digest_word, want.word);
        if (word_index !== want.word_pos)
            report_mismatch("word_index", 32'(word_index), 32'(want.word_pos));
        if (last_word !== want.last_mark)
            report_mismatch("last_word", 32'(last_word), 32'(want.last_mark));
        words_checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_digest();
            expected_words.delete();
            mismatch_count = 0;
            words_checked  = 0;
            words_pending  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_word();
            if (in_valid && !in_stall)
            begin
                if (command == CMD_FINISH)
                    close_message();
                else
                    absorb_byte(message_byte);
            end
            words_pending = expected_words.size();
        end
    end

endmodule

[tb/tb_sha256_stream_hasher_unit.sv]
// top of the sha-256 stream hasher testbench: clock, reset, stimulus, stall pattern and verdict
`timescale 1ns / 100ps

module tb_sha256_stream_hasher_unit;
    import shs_tb_pkg::*;

    // total item budget, and the point after which both sides stop idling
    localparam int ITEM_TARGET    = 460;
    localparam int CALM_FROM      = 390;
    // long receiver hold-off, long enough to back the block up into its input
    localparam int HOLD_CYCLES    = 300;
    // room for two compressions plus the digest words, with margin
    localparam int DRAIN_CYCLES   = 200;
    // worst quiet stretch: hold-off plus two compressions plus idle bursts, times several
    localparam int WATCHDOG_LIMIT = 2000;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic        command      = 1'b0;
    logic [7:0]  message_byte = 8'h00;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    int mismatch_count;
    int words_pending;
    int words_checked;

    // stimulus bookkeeping and control; the counts also feed the closing summary
    int         items_sent    = 0;
    int         messages_sent = 0;
    int         longest_msg   = 0;
    int         holds_done    = 0;
    bit         idle_on       = 1'b1;
    bit         hold_request  = 1'b0;
    logic [7:0] msg_bytes [$];

    sha256_stream_hasher_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .message_byte (message_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .digest_word  (digest_word),
        .word_index   (word_index),
        .last_word    (last_word)
    );

    sha256_digest_checker checker_i
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .message_byte   (message_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending),
        .words_checked  (words_checked)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // single reset at the start of the run, released on a clock edge
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // offer one item and hold it until the block takes it; entered and left on a
    // rising edge, so valid is only ever written once per edge
    task automatic send_item(input hash_cmd_e cmd, input logic [7:0] value);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        message_byte <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // absorb every byte of msg_bytes, then close the message; the finish item
    // carries a random byte, which the block must ignore
    task automatic send_message();
        foreach (msg_bytes[i])
            send_item(CMD_ABSORB, msg_bytes[i]);
        send_item(CMD_FINISH, 8'($urandom_range(0, 255)));
        messages_sent++;
        if (msg_bytes.size() > longest_msg)
            longest_msg = msg_bytes.size();
    endtask

    // pick a message length: mostly short, some right at the padding boundaries
    // (length just fits, spills into a second block, exact block multiples), a few long
    function automatic int pick_length();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 86)
            return $urandom_range(0, 15);
        if (sel < 96)
        begin
            case ($urandom_range(0, 7))
                0: return 55;
                1: return 56;
                2: return 57;
                3: return 63;
                4: return 64;
                5: return 65;
                6: return 119;
                default: return 120;
            endcase
        end
        return $urandom_range(66, 130);
    endfunction

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall    <= 1'b0;
                hold_request  = 1'b0;
                holds_done++;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog: ends the run if neither channel moves for too long
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no item moved for %0d cycles, %0d digest words outstanding",
                 quiet_cycles, words_pending);
        $display("Regression FAIL");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        int len;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // directed: empty message, a short ascii string, and the byte extremes
        msg_bytes.delete();
        send_message();
        msg_bytes.delete();
        msg_bytes.push_back(8'h61);
        msg_bytes.push_back(8'h62);
        msg_bytes.push_back(8'h63);
        send_message();
        msg_bytes.delete();
        msg_bytes.push_back(8'h00);
        msg_bytes.push_back(8'hff);
        send_message();
        // back-to-back finish items, i.e. a second empty message right away
        msg_bytes.delete();
        send_message();

        // random messages with random content until the item budget is spent
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= CALM_FROM)
                idle_on = 1'b0;
            len = pick_length();
            // keep the total close to the item budget
            if (len > ITEM_TARGET - items_sent)
                len = ITEM_TARGET - items_sent;
            // one short message under a long receiver hold-off: the finish backs
            // up behind the stalled digest words and the input stalls
            if (messages_sent == 8)
            begin
                hold_request = 1'b1;
                len          = 5;
            end
            msg_bytes.delete();
            for (int i = 0; i < len; i++)
                msg_bytes.push_back(8'($urandom_range(0, 255)));
            send_message();
        end
        idle_on   = 1'b0;
        in_valid <= 1'b0;
        // one edge so the checker has queued the last digest before we wait on it
        @(posedge clk);

        // let every digest come out, then watch a while for stray words
        while (words_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d items in %0d messages (longest %0d bytes), %0d words checked",
                 items_sent, messages_sent, longest_msg, words_checked);
        $display("receiver hold-offs of %0d cycles: %0d, idle bursts on both sides until item %0d",
                 HOLD_CYCLES, holds_done, CALM_FROM);
        if (mismatch_count == 0 && words_pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
